// ===== src/rti_pkg.sv =====
`timescale 1ns / 1ps

package rti_pkg;

  // default coordinate width, legal range 8 to 20
  localparam int COORD_WIDTH_DEF = 16;

  // configuration port
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 32;
  localparam int EPS_WIDTH       = 32;

  localparam logic [EPS_WIDTH-1:0] EPS_RESET = EPS_WIDTH'(1);

  // entries in the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_DIR_X    = 3'd0,
    REG_DIR_Y    = 3'd1,
    REG_DIR_Z    = 3'd2,
    REG_ORIGIN_X = 3'd3,
    REG_ORIGIN_Y = 3'd4,
    REG_ORIGIN_Z = 3'd5,
    REG_EPSILON  = 3'd6
  } reg_index_t;

endpackage

// ===== src/rti_front.sv =====
`timescale 1ns / 1ps

module rti_front #(
  parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] v0_x,
  input  logic signed [COORD_WIDTH-1:0] v0_y,
  input  logic signed [COORD_WIDTH-1:0] v0_z,
  input  logic signed [COORD_WIDTH-1:0] v1_x,
  input  logic signed [COORD_WIDTH-1:0] v1_y,
  input  logic signed [COORD_WIDTH-1:0] v1_z,
  input  logic signed [COORD_WIDTH-1:0] v2_x,
  input  logic signed [COORD_WIDTH-1:0] v2_y,
  input  logic signed [COORD_WIDTH-1:0] v2_z,
  input  logic signed [COORD_WIDTH-1:0] dir_x,
  input  logic signed [COORD_WIDTH-1:0] dir_y,
  input  logic signed [COORD_WIDTH-1:0] dir_z,
  input  logic signed [COORD_WIDTH-1:0] origin_x,
  input  logic signed [COORD_WIDTH-1:0] origin_y,
  input  logic signed [COORD_WIDTH-1:0] origin_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [9*(COORD_WIDTH+1)+6*(2*COORD_WIDTH+3)-1:0] out_data
);
  import rti_pkg::*;

  localparam int EW = COORD_WIDTH + 1;
  localparam int PW = 2 * COORD_WIDTH + 3;

  // stage 1: edges and origin offset
  logic              s1_valid;
  logic              s1_ready;
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [EW-1:0] so [3];

  // stage 2: cross products p = dir x e2, q = s x e1
  logic              s2_valid;
  logic              s2_ready;
  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];
  logic signed [EW-1:0] so_r [3];
  logic signed [PW-1:0] p [3];
  logic signed [PW-1:0] q [3];

  logic signed [PW-1:0] dir_w [3];
  logic signed [PW-1:0] e1_w [3];
  logic signed [PW-1:0] e2_w [3];
  logic signed [PW-1:0] so_w [3];

  assign s2_ready = !s2_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
    if (s1_ready && in_valid) begin
      e1[0] <= EW'(v1_x) - EW'(v0_x);
      e1[1] <= EW'(v1_y) - EW'(v0_y);
      e1[2] <= EW'(v1_z) - EW'(v0_z);
      e2[0] <= EW'(v2_x) - EW'(v0_x);
      e2[1] <= EW'(v2_y) - EW'(v0_y);
      e2[2] <= EW'(v2_z) - EW'(v0_z);
      so[0] <= EW'(origin_x) - EW'(v0_x);
      so[1] <= EW'(origin_y) - EW'(v0_y);
      so[2] <= EW'(origin_z) - EW'(v0_z);
    end
  end

  // operands widened to the cross product width
  assign dir_w[0] = PW'(dir_x);
  assign dir_w[1] = PW'(dir_y);
  assign dir_w[2] = PW'(dir_z);
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1_w[i] = PW'(e1[i]);
      e2_w[i] = PW'(e2[i]);
      so_w[i] = PW'(so[i]);
    end
  end

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
    if (s2_ready && s1_valid) begin
      p[0] <= dir_w[1] * e2_w[2] - dir_w[2] * e2_w[1];
      p[1] <= dir_w[2] * e2_w[0] - dir_w[0] * e2_w[2];
      p[2] <= dir_w[0] * e2_w[1] - dir_w[1] * e2_w[0];
      q[0] <= so_w[1] * e1_w[2] - so_w[2] * e1_w[1];
      q[1] <= so_w[2] * e1_w[0] - so_w[0] * e1_w[2];
      q[2] <= so_w[0] * e1_w[1] - so_w[1] * e1_w[0];
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= e1[i];
        e2_r[i] <= e2[i];
        so_r[i] <= so[i];
      end
    end
  end

  assign out_valid = s2_valid;
  assign out_data  = {e1_r[0], e1_r[1], e1_r[2], e2_r[0], e2_r[1], e2_r[2],
                      so_r[0], so_r[1], so_r[2], p[0], p[1], p[2],
                      q[0], q[1], q[2]};

endmodule

// ===== src/rti_queue.sv =====
`timescale 1ns / 1ps

module rti_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);
  import rti_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_PTR   = AW'(QUEUE_DEPTH - 1);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != FULL_COUNT);
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == LAST_PTR) ? '0 : wptr + AW'(1);
      end
      if (pop) begin
        rptr <= (rptr == LAST_PTR) ? '0 : rptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  // fill count stays within the storage
  assert property (@(posedge clk) disable iff (rst) count <= FULL_COUNT)
    else $error("queue count beyond depth");

  // an entry written into an empty queue is offered on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (count == '0) && push |=> out_valid)
    else $error("queue lost a transfer");

  // pointers stay in step with the count
  assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wptr == rptr))
    else $error("queue pointers out of step");

endmodule

// ===== src/rti_back.sv =====
`timescale 1ns / 1ps

module rti_back #(
  parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [9*(COORD_WIDTH+1)+6*(2*COORD_WIDTH+3)-1:0] in_data,
  input  logic signed [COORD_WIDTH-1:0] dir_x,
  input  logic signed [COORD_WIDTH-1:0] dir_y,
  input  logic signed [COORD_WIDTH-1:0] dir_z,
  input  logic [rti_pkg::EPS_WIDTH-1:0] det_epsilon,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit
);
  import rti_pkg::*;

  localparam int EW = COORD_WIDTH + 1;
  localparam int PW = 2 * COORD_WIDTH + 3;
  localparam int DW = 3 * COORD_WIDTH + 5;
  localparam int MW = (DW > EPS_WIDTH + 1) ? DW : EPS_WIDTH + 1;

  // signed zero so the range tests stay signed compares
  localparam logic signed [DW-1:0] ZERO = '0;

  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [EW-1:0] so [3];
  logic signed [PW-1:0] p [3];
  logic signed [PW-1:0] q [3];
  logic signed [DW-1:0] dir_w [3];

  // stage 1: the twelve products of the four dot products
  logic                 b1_valid;
  logic                 b1_ready;
  logic signed [DW-1:0] pd_det [3];
  logic signed [DW-1:0] pd_u [3];
  logic signed [DW-1:0] pd_v [3];
  logic signed [DW-1:0] pd_t [3];

  // stage 2: sums
  logic                 b2_valid;
  logic                 b2_ready;
  logic signed [DW-1:0] det;
  logic signed [DW-1:0] ndet;
  logic signed [DW-1:0] u;
  logic signed [DW-1:0] v;
  logic signed [DW-1:0] t;
  logic signed [DW-1:0] uv;

  // stage 3: range tests
  logic          det_neg;
  logic [MW-1:0] det_mag;
  logic          det_ok;
  logic          u_ok;
  logic          v_ok;
  logic          t_ok;
  logic          hit_next;

  assign {e1[0], e1[1], e1[2], e2[0], e2[1], e2[2], so[0], so[1], so[2],
          p[0], p[1], p[2], q[0], q[1], q[2]} = in_data;

  assign dir_w[0] = DW'(dir_x);
  assign dir_w[1] = DW'(dir_y);
  assign dir_w[2] = DW'(dir_z);

  assign b2_ready = !b2_valid || !out_valid || out_ready;
  assign b1_ready = !b1_valid || b2_ready;
  assign in_ready = b1_ready;

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (b1_ready) begin
      b1_valid <= in_valid;
    end
    if (b1_ready && in_valid) begin
      for (int i = 0; i < 3; i++) begin
        pd_det[i] <= DW'(e1[i]) * DW'(p[i]);
        pd_u[i]   <= DW'(so[i]) * DW'(p[i]);
        pd_v[i]   <= dir_w[i] * DW'(q[i]);
        pd_t[i]   <= DW'(e2[i]) * DW'(q[i]);
      end
    end
  end

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      b2_valid <= 1'b0;
    end else if (b2_ready) begin
      b2_valid <= b1_valid;
    end
    if (b2_ready && b1_valid) begin
      det  <= pd_det[0] + pd_det[1] + pd_det[2];
      ndet <= '0 - pd_det[0] - pd_det[1] - pd_det[2];
      u    <= pd_u[0] + pd_u[1] + pd_u[2];
      v    <= pd_v[0] + pd_v[1] + pd_v[2];
      t    <= pd_t[0] + pd_t[1] + pd_t[2];
      uv   <= pd_u[0] + pd_u[1] + pd_u[2] + pd_v[0] + pd_v[1] + pd_v[2];
    end
  end

  // sign of det folded into each comparison
  always_comb begin
    det_neg  = det[DW-1];
    det_mag  = det_neg ? MW'($unsigned(ndet)) : MW'($unsigned(det));
    det_ok   = (det != '0) && (det_mag >= MW'(det_epsilon));
    u_ok     = det_neg ? (u <= ZERO && u >= det) : (u >= ZERO && u <= det);
    v_ok     = det_neg ? (v <= ZERO && uv >= det) : (v >= ZERO && uv <= det);
    t_ok     = det_neg ? (t <= ZERO) : (t >= ZERO);
    hit_next = det_ok && u_ok && v_ok && t_ok;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= b2_valid;
    end
    if ((!out_valid || out_ready) && b2_valid) begin
      hit <= hit_next;
    end
  end

  // a zero determinant never reports a hit
  assert property (@(posedge clk) disable iff (rst)
    b2_valid && b2_ready && (det == '0) |=> out_valid && !hit)
    else $error("zero determinant reported as hit");

  // stage 2 holds its sums while the output is stalled
  assert property (@(posedge clk) disable iff (rst)
    b2_valid && !b2_ready |=> b2_valid && $stable(det) && $stable(uv))
    else $error("stage 2 changed under stall");

endmodule

// ===== src/ray_triangle_intersect_unit.sv =====
`timescale 1ns / 1ps

// Moller-Trumbore ray/triangle hit test, one triangle per transfer on the input
// channel and one hit bit per transfer on the output channel, in order. The ray
// (direction, origin) and det_epsilon sit in configuration registers written
// through the cfg channel (cfg_ready is always high; index 0..2 direction,
// 3..5 origin, 6 epsilon, other indexes ignored); the user must write them only
// while no triangle is in flight, which the block does not enforce. All
// coordinates share one signed fixed-point format of COORD_WIDTH bits. Sustained
// rate is one triangle per clock while the output is not stalled: every multiply
// level sits in its own pipeline stage (two front stages for edges and cross
// products, three back stages for dot-product terms, sums and range tests). A
// four-entry queue between front and back absorbs output backpressure.
module ray_triangle_intersect_unit #(
  parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_WIDTH-1:0]       v0_x,
  input  logic signed [COORD_WIDTH-1:0]       v0_y,
  input  logic signed [COORD_WIDTH-1:0]       v0_z,
  input  logic signed [COORD_WIDTH-1:0]       v1_x,
  input  logic signed [COORD_WIDTH-1:0]       v1_y,
  input  logic signed [COORD_WIDTH-1:0]       v1_z,
  input  logic signed [COORD_WIDTH-1:0]       v2_x,
  input  logic signed [COORD_WIDTH-1:0]       v2_y,
  input  logic signed [COORD_WIDTH-1:0]       v2_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                hit,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rti_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [rti_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
  import rti_pkg::*;

  localparam int QW = 9 * (COORD_WIDTH + 1) + 6 * (2 * COORD_WIDTH + 3);

  logic signed [COORD_WIDTH-1:0] dir_x;
  logic signed [COORD_WIDTH-1:0] dir_y;
  logic signed [COORD_WIDTH-1:0] dir_z;
  logic signed [COORD_WIDTH-1:0] origin_x;
  logic signed [COORD_WIDTH-1:0] origin_y;
  logic signed [COORD_WIDTH-1:0] origin_z;
  logic [EPS_WIDTH-1:0]          det_epsilon;

  logic          fq_valid;
  logic          fq_ready;
  logic [QW-1:0] fq_data;
  logic          qb_valid;
  logic          qb_ready;
  logic [QW-1:0] qb_data;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dir_x       <= '0;
      dir_y       <= '0;
      dir_z       <= '0;
      origin_x    <= '0;
      origin_y    <= '0;
      origin_z    <= '0;
      det_epsilon <= EPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DIR_X:    dir_x       <= cfg_data[COORD_WIDTH-1:0];
        REG_DIR_Y:    dir_y       <= cfg_data[COORD_WIDTH-1:0];
        REG_DIR_Z:    dir_z       <= cfg_data[COORD_WIDTH-1:0];
        REG_ORIGIN_X: origin_x    <= cfg_data[COORD_WIDTH-1:0];
        REG_ORIGIN_Y: origin_y    <= cfg_data[COORD_WIDTH-1:0];
        REG_ORIGIN_Z: origin_z    <= cfg_data[COORD_WIDTH-1:0];
        REG_EPSILON:  det_epsilon <= cfg_data[EPS_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: edges and cross products
  rti_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .v0_x     (v0_x),
    .v0_y     (v0_y),
    .v0_z     (v0_z),
    .v1_x     (v1_x),
    .v1_y     (v1_y),
    .v1_z     (v1_z),
    .v2_x     (v2_x),
    .v2_y     (v2_y),
    .v2_z     (v2_z),
    .dir_x    (dir_x),
    .dir_y    (dir_y),
    .dir_z    (dir_z),
    .origin_x (origin_x),
    .origin_y (origin_y),
    .origin_z (origin_z),
    .out_valid(fq_valid),
    .out_ready(fq_ready),
    .out_data (fq_data)
  );

  // decoupling queue
  rti_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fq_valid),
    .in_ready (fq_ready),
    .in_data  (fq_data),
    .out_valid(qb_valid),
    .out_ready(qb_ready),
    .out_data (qb_data)
  );

  // back: dot products and range tests
  rti_back #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (qb_valid),
    .in_ready   (qb_ready),
    .in_data    (qb_data),
    .dir_x      (dir_x),
    .dir_y      (dir_y),
    .dir_z      (dir_z),
    .det_epsilon(det_epsilon),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit        (hit)
  );

endmodule
